// ----- sv/fmsp_pkg.sv -----
// Shared types and constants for the split-partial fp32 multiplier.
package fmsp_pkg;
    localparam int unsigned WORD_W = 32;
    localparam int unsigned HI_W   = 13;
    localparam int unsigned LO_W   = 11;
    localparam int unsigned MANT_W = 26;
    localparam logic [8:0] EXP_BIAS_ADJ = 9'h081;
    localparam logic [MANT_W-1:0] ROUND_K = 26'd2;

    typedef logic [WORD_W-1:0] t_word;

    typedef struct packed {
        logic             sign;
        logic [8:0]       esum;
        logic [HI_W-1:0]  ah;
        logic [HI_W-1:0]  bh;
        logic [LO_W-1:0]  al;
        logic [LO_W-1:0]  bl;
    } t_unpack;

    typedef struct packed {
        logic             sign;
        logic [8:0]       esum;
        logic [MANT_W-1:0] hh;
        logic [12:0]      cross_a;
        logic [12:0]      cross_b;
    } t_prod;
endpackage

// ----- sv/fp32_multiply_split_partial_top.sv -----
// Top level: four-stage pipelined fp32 multiplier with split, truncated mantissa product.
//
//  channel | valid      | stall      | payload
//  in      | i_valid    | o_stall    | i_operand_a, i_operand_b
//  out     | o_valid    | i_stall    | o_product
//
// One beat per cycle while no stall holds the pipe; o_valid is the stage-4 valid bit.
// Stage 1 unpacks, stage 2 forms the three partial products, stage 3 sums,
// stage 4 normalizes/packs. Synchronous active-low reset clears valid bits.
// A downstream stall holds every occupied stage whose successor is held; bubbles
// collapse, so o_stall rises only when the whole pipe is full and stalled.
module fp32_multiply_split_partial_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  fmsp_pkg::t_word   i_operand_a,
    input  fmsp_pkg::t_word   i_operand_b,
    output logic              o_valid,
    input  logic              i_stall,
    output fmsp_pkg::t_word   o_product
);
    import fmsp_pkg::*;

    logic [3:0] r_v;
    logic [3:0] adv;
    t_unpack r_s1;
    t_prod   r_s2;
    logic             r_s3_sign;
    logic [8:0]       r_s3_esum;
    logic [MANT_W-1:0] r_s3_mant;
    t_word   r_s4;

    logic [2*HI_W-1:0]    ahbl, albh;
    logic [MANT_W-1:0]    n_mant;
    t_word                n_prod;

    assign adv[3] = !r_v[3] || !i_stall;
    assign adv[2] = !r_v[2] || adv[3];
    assign adv[1] = !r_v[1] || adv[2];
    assign adv[0] = !r_v[0] || adv[1];
    assign o_stall = !adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[0]) r_v[0] <= i_valid;
            if (adv[1]) r_v[1] <= r_v[0];
            if (adv[2]) r_v[2] <= r_v[1];
            if (adv[3]) r_v[3] <= r_v[2];
        end
    end

    // 13x11 cross products, bits 23..11 kept
    assign ahbl = {13'd0, r_s1.ah} * {15'd0, r_s1.bl};
    assign albh = {15'd0, r_s1.al} * {13'd0, r_s1.bh};
    assign n_mant = r_s2.hh + {13'd0, r_s2.cross_a} + {13'd0, r_s2.cross_b} + ROUND_K;

    always_comb begin
        n_prod = '0;
        if (r_s3_esum[8]) begin
            if (r_s3_mant[25]) begin
                n_prod = {r_s3_sign, r_s3_esum[7:0] + 8'd1, r_s3_mant[24:2]};
            end else begin
                n_prod = {r_s3_sign, r_s3_esum[7:0], r_s3_mant[23:1]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_s1.sign <= i_operand_a[31] ^ i_operand_b[31];
            r_s1.esum <= {1'b0, i_operand_a[30:23]} + {1'b0, i_operand_b[30:23]} + EXP_BIAS_ADJ;
            r_s1.ah   <= {1'b1, i_operand_a[22:11]};
            r_s1.bh   <= {1'b1, i_operand_b[22:11]};
            r_s1.al   <= i_operand_a[10:0];
            r_s1.bl   <= i_operand_b[10:0];
        end
        if (adv[1]) begin
            r_s2.sign    <= r_s1.sign;
            r_s2.esum    <= r_s1.esum;
            r_s2.hh      <= {13'd0, r_s1.ah} * {13'd0, r_s1.bh};
            r_s2.cross_a <= ahbl[23:11];
            r_s2.cross_b <= albh[23:11];
        end
        if (adv[2]) begin
            r_s3_sign <= r_s2.sign;
            r_s3_esum <= r_s2.esum;
            r_s3_mant <= n_mant;
        end
        if (adv[3]) begin
            r_s4 <= n_prod;
        end
    end

    assign o_valid   = r_v[3];
    assign o_product = r_s4;
endmodule
